[hdl/lcd_pkg.sv]
package lcd_pkg;

  localparam int unsigned NUM_SETS   = 128;
  localparam int unsigned NUM_WAYS   = 8;
  localparam int unsigned LINE_BYTES = 32;

  localparam int unsigned OFS_W  = $clog2(LINE_BYTES);
  localparam int unsigned SET_W  = $clog2(NUM_SETS);
  localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned TREE_N = 2 ** WAY_W;
  localparam int unsigned TAG_W  = 32 - OFS_W - SET_W;
  localparam int unsigned LINE_W = 27;
  localparam int unsigned AGE_W  = 32;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_STORE     = 3'd1,
    OP_ZERO      = 3'd2,
    OP_CLEAN     = 3'd3,
    OP_CLEAN_INV = 3'd4,
    OP_KILL      = 3'd5,
    OP_SNOOP_RD  = 3'd6,
    OP_SNOOP_WR  = 3'd7
  } op_e;

  localparam int unsigned ATTR_WT = 3;
  localparam int unsigned ATTR_CI = 2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address;
    logic [3:0]  length;
    logic [3:0]  page_attributes;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [2:0]        way;
    logic              line_used;
    logic              bypass;
    logic              bus_write;
    logic              writeback_valid;
    logic [LINE_W-1:0] writeback_line;
    logic              fill_valid;
    logic              zero_fill;
    logic              crosses_block;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } entry_t;

  localparam int unsigned ROW_W = NUM_WAYS * $bits(entry_t);

endpackage

[hdl/lcd_ram.sv]
module lcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/l1_data_cache_directory.sv]
// Channel      Direction  Handshake                      Payload
// request      in         start_i & !busy_o              req_i (lcd_pkg::req_t)
// result       out        result_valid_o (one cycle)     rsp_o (lcd_pkg::rsp_t)
// config       in         cfg_valid_i & cfg_ready_o      cfg_data_i (cache enable)
//
// Per item, the set row is read from the directory memory in the cycle of
// acceptance, and in the following cycle (busy high) the row is evaluated,
// written back and the result registered; the result strobe is high in the
// cycle after that, when a new item may already be taken. The memory's single
// read port and one read-modify-write per item keep a new item out while busy.
// Reset clears the row valid flags, the use clock and the enable; a row never
// written reads as all-invalid. The receiver cannot stall the result.
module l1_data_cache_directory (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  lcd_pkg::req_t req_i,
  output logic          result_valid_o,
  output lcd_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);

  import lcd_pkg::*;

  // The sequencer is either waiting for an item or evaluating a row.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic               state_q, state_d;
  logic               enable_q;
  logic [AGE_W-1:0]   clock_q, clock_d;
  logic [NUM_SETS-1:0] rowv_q;
  req_t               req_q;
  rsp_t               rsp_q, rsp_d;
  logic               strobe_q;

  logic               accept;
  logic [ROW_W-1:0]   rdata, wdata;
  entry_t             ways [NUM_WAYS];
  entry_t             nways [NUM_WAYS];

  logic [SET_W-1:0]   set;
  logic [TAG_W-1:0]   tag;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q == ST_EVAL);
  assign cfg_ready_o = 1'b1;
  assign set         = req_q.address[OFS_W +: SET_W];
  assign tag         = req_q.address[31 -: TAG_W];

  lcd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_dir (
    .clk_i   (clk_i),
    .we_i    (busy_o),
    .waddr_i (set),
    .wdata_i (wdata),
    .raddr_i (req_i.address[OFS_W +: SET_W]),
    .rdata_o (rdata)
  );

  // Unpack the row; a row that was never written reads as the reset value.
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      ways[i] = rowv_q[set] ? entry_t'(rdata[i*$bits(entry_t) +: $bits(entry_t)])
                            : entry_t'('0);
    end
  end

  // Lookup: lowest valid way whose tag matches; first invalid way.
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             inv_found;
  logic [WAY_W-1:0] inv_way;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (ways[i].valid && ways[i].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!ways[i].valid) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end
  end

  // Oldest stamp by a comparison tree; ties keep the lower way.
  logic [AGE_W-1:0] node_age [2*TREE_N];
  logic [WAY_W-1:0] node_idx [2*TREE_N];

  always_comb begin
    node_age[0] = '0;
    node_idx[0] = '0;
    for (int i = 0; i < TREE_N; i++) begin
      node_age[TREE_N+i] = (i < NUM_WAYS) ? ways[i].age : '1;
      node_idx[TREE_N+i] = WAY_W'(i);
    end
    for (int n = TREE_N - 1; n >= 1; n--) begin
      if (node_age[2*n+1] < node_age[2*n]) begin
        node_age[n] = node_age[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_age[n] = node_age[2*n];
        node_idx[n] = node_idx[2*n];
      end
    end
  end

  logic [WAY_W-1:0] victim;
  assign victim = inv_found ? inv_way : node_idx[1];

  // Evaluate the item against the row and build the new row.
  logic             crosses;
  logic [OFS_W:0]   span;
  logic [WAY_W-1:0] w;
  logic             do_alloc, do_stamp;

  assign span    = {1'b0, req_q.address[OFS_W-1:0]} + (OFS_W + 1)'(req_q.length);
  assign crosses = span > (OFS_W + 1)'(LINE_BYTES);

  always_comb begin
    nways    = ways;
    rsp_d    = '0;
    clock_d  = clock_q;
    w        = hit_way;
    do_alloc = 1'b0;
    do_stamp = 1'b0;
    unique case (op_e'(req_q.operation))
      OP_LOAD, OP_STORE: begin
        if (!enable_q || req_q.page_attributes[ATTR_CI]) begin
          rsp_d.bypass = 1'b1;
        end else if (crosses) begin
          rsp_d.crosses_block = 1'b1;
        end else begin
          rsp_d.hit = hit;
          do_stamp  = hit;
          if (req_q.operation == OP_STORE && req_q.page_attributes[ATTR_WT]) begin
            rsp_d.bus_write = 1'b1;
            rsp_d.line_used = hit;
          end else begin
            do_alloc         = !hit;
            rsp_d.fill_valid = !hit;
            rsp_d.line_used  = 1'b1;
          end
        end
      end
      OP_ZERO: begin
        rsp_d.hit       = hit;
        do_stamp        = hit;
        do_alloc        = !hit;
        rsp_d.line_used = 1'b1;
        rsp_d.zero_fill = 1'b1;
      end
      OP_CLEAN, OP_CLEAN_INV, OP_KILL: begin
        rsp_d.hit = hit;
        do_stamp  = hit;
      end
      OP_SNOOP_RD, OP_SNOOP_WR: begin
        if (enable_q && req_q.length != '0) begin
          if (crosses) begin
            rsp_d.crosses_block = 1'b1;
          end else begin
            rsp_d.hit = hit;
          end
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase

    if (do_alloc) begin
      w = victim;
      if (!inv_found && ways[victim].dirty) begin
        rsp_d.writeback_valid = 1'b1;
        rsp_d.writeback_line  = LINE_W'({ways[victim].tag, set});
      end
      nways[w].tag   = tag;
      nways[w].valid = 1'b1;
      nways[w].dirty = 1'b0;
    end
    if (do_stamp || do_alloc) begin
      clock_d         = clock_q + 1'b1;
      nways[w].age    = clock_d;
    end

    if (rsp_d.hit || do_alloc) begin
      rsp_d.way = 3'(w);
    end

    // Dirty marking, write-backs and invalidations on a hit or allocation.
    if (rsp_d.line_used && !rsp_d.bus_write
        && (req_q.operation == OP_STORE || req_q.operation == OP_ZERO)) begin
      nways[w].dirty = 1'b1;
    end
    if (rsp_d.hit && (req_q.operation == OP_CLEAN || req_q.operation == OP_CLEAN_INV
                      || req_q.operation == OP_SNOOP_RD
                      || req_q.operation == OP_SNOOP_WR)) begin
      if (ways[w].dirty) begin
        rsp_d.writeback_valid = 1'b1;
        rsp_d.writeback_line  = LINE_W'(req_q.address[31:OFS_W]);
        rsp_d.line_used       = 1'b1;
        nways[w].dirty        = 1'b0;
      end
    end
    if (rsp_d.hit && (req_q.operation == OP_CLEAN_INV || req_q.operation == OP_KILL
                      || req_q.operation == OP_SNOOP_WR)) begin
      nways[w].valid = 1'b0;
      nways[w].dirty = 1'b0;
    end

    for (int i = 0; i < NUM_WAYS; i++) begin
      wdata[i*$bits(entry_t) +: $bits(entry_t)] = nways[i];
    end
  end

  assign state_d = accept ? ST_EVAL : ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      enable_q <= 1'b0;
      clock_q  <= '0;
      rowv_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= busy_o;
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
      if (busy_o) begin
        clock_q     <= clock_d;
        rowv_q[set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (busy_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = strobe_q;
  assign rsp_o          = rsp_q;

`ifndef SYNTHESIS
  a_result_follows_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> result_valid_o)
    else $error("result strobe did not follow evaluation");
  a_single_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("evaluation lasted more than one cycle");
  a_cross_no_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.crosses_block |-> !rsp_o.line_used && !rsp_o.hit)
    else $error("rejected item used a line");
  a_bypass_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.bypass |-> !rsp_o.hit && !rsp_o.fill_valid)
    else $error("bypassed item touched the directory");
`endif

endmodule
